>>> design/watchdog_timer_with_pet_key_unit_defines.svh
// Assertion macros for the watchdog unit.
// Each sampled on the rising clock edge, off while reset is asserted.
`ifndef WATCHDOG_TIMER_WITH_PET_KEY_UNIT_DEFINES_SVH
`define WATCHDOG_TIMER_WITH_PET_KEY_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WDT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/wdt_pkg.sv
`timescale 1ns / 1ps

package wdt_pkg;

	// Width of the reload value and countdown
	localparam int COUNT_BITS = 31;

	localparam logic [7:0] PET_KEY = 8'h5A;
	localparam int DISABLE_BIT = 31;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_READ  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		REG_TIMER  = 2'd0,
		REG_STATUS = 2'd1,
		REG_PET    = 2'd2
	} reg_t;

	typedef struct packed {
		req_t        req_type;
		reg_t        reg_index;
		logic [31:0] write_data;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        bitten;
	} result_t;

endpackage

>>> design/watchdog_timer_with_pet_key_unit.sv
`timescale 1ns / 1ps
// Path: an accepted input word passes the input register, then the result
// register, and is offered on the output when the output is not stalled.
// Throughput: one word per cycle unless the output stalls, ticks and
// register accesses alike; state updates between the two registers.
// Reset: arst_n clears the watchdog to disabled, not expired, zero reload.

module watchdog_timer_with_pet_key_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [1:0]  reg_index,
	input  logic [31:0] write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        bitten
);
	import wdt_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	logic    out_valid_q;
	logic [31:0] read_data_q;
	logic    bitten_q;

	logic out_free;
	logic advance;
	logic accept;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.req_type   <= req_t'(req_type);
			item_s1.reg_index  <= reg_t'(reg_index);
			item_s1.write_data <= write_data;
		end
	end

	wdt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// Result register, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= result.read_data;
			bitten_q    <= result.bitten;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign bitten    = bitten_q;

endmodule

>>> design/wdt_core.sv
`timescale 1ns / 1ps

module wdt_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  wdt_pkg::item_t  item,
	output wdt_pkg::result_t result
);
	import wdt_pkg::*;

	logic [COUNT_BITS-1:0] reload_q;
	logic [COUNT_BITS-1:0] countdown_q;
	logic                  disabled_q;
	logic                  expired_q;

	logic [COUNT_BITS-1:0] reload_d;
	logic [COUNT_BITS-1:0] countdown_d;
	logic                  disabled_d;
	logic                  expired_d;
	logic [31:0]           rd;

	// Work out the state after this word
	always_comb begin
		reload_d    = reload_q;
		countdown_d = countdown_q;
		disabled_d  = disabled_q;
		expired_d   = expired_q;
		case (item.req_type)
			REQ_TICK: begin
				if (!disabled_q && !expired_q) begin
					if (countdown_q == '0) begin
						expired_d = 1'b1;
					end else begin
						countdown_d = countdown_q - 1'b1;
					end
				end
			end
			REQ_WRITE: begin
				case (item.reg_index)
					REG_TIMER: begin
						disabled_d  = item.write_data[DISABLE_BIT];
						reload_d    = item.write_data[COUNT_BITS-1:0];
						countdown_d = item.write_data[COUNT_BITS-1:0];
					end
					REG_STATUS: begin
						expired_d = item.write_data[0];
					end
					REG_PET: begin
						if (item.write_data[31:24] == PET_KEY) begin
							countdown_d = reload_q;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Read mux, zero unless this word is a read
	always_comb begin
		rd = '0;
		if (item.req_type == REQ_READ) begin
			case (item.reg_index)
				REG_TIMER: begin
					rd[COUNT_BITS-1:0] = reload_q;
					rd[DISABLE_BIT]    = disabled_q;
				end
				REG_STATUS: begin
					rd[0] = expired_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign result.read_data = rd;
	assign result.bitten    = expired_d;

	// Commit the state when the word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q    <= '0;
			countdown_q <= '0;
			disabled_q  <= 1'b1;
			expired_q   <= 1'b0;
		end else if (step) begin
			reload_q    <= reload_d;
			countdown_q <= countdown_d;
			disabled_q  <= disabled_d;
			expired_q   <= expired_d;
		end
	end

endmodule

>>> design/wdt_checker.sv
`timescale 1ns / 1ps
`include "watchdog_timer_with_pet_key_unit_defines.svh"

module wdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  req_type,
	input logic [1:0]  reg_index,
	input logic [31:0] write_data,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_data,
	input logic        bitten
);

	logic        in_held;
	logic        in_take;
	logic        out_held;
	logic        out_free;
	logic [35:0] in_word;
	logic [32:0] out_word;

	// Gather handshake states and payloads
	assign in_held  = in_valid && in_stall;
	assign in_take  = in_valid && !in_stall;
	assign out_held = out_valid && out_stall;
	assign out_free = !out_valid || !out_stall;
	assign in_word  = {req_type, reg_index, write_data};
	assign out_word = {read_data, bitten};

	// A stalled result word stays offered
	`WDT_ASSERT_NEXT(a_out_hold, out_held, out_valid, "result word dropped while stalled")

	// A stalled result word keeps its payload
	`WDT_ASSERT_NEXT(a_out_stable, out_held, $stable(out_word), "result payload moved")

	// Input backs up only when the output side is full and stalled
	`WDT_ASSERT_SAME(a_stall_cause, in_stall, out_held, "input stalled with free output")

	// An accepted word reaches the output in the cycle after the output frees
	`WDT_ASSERT_NEXT(a_latency, in_take ##1 out_free, out_valid, "result word missing")

	// A stalled input word stays offered with its payload
	`WDT_ASSERT_NEXT(a_in_stable, in_held, in_valid && $stable(in_word), "input word moved")

endmodule

bind watchdog_timer_with_pet_key_unit wdt_checker u_wdt_checker (.*);
